@@ sv/ppasf_pkg.sv @@
// Shared constants, codes and word types of the ping-pong audio stream feeder.
package ppasf_pkg;

   localparam int ADDR_W      = 32;
   localparam int SIZE_W      = 24;
   localparam int CW_W        = 16;
   localparam int CREDIT_W    = 16;
   localparam int BLOCK_WORDS = 240;
   localparam int MAX_REC     = 5;
   localparam int REC_IDX_W   = $clog2(MAX_REC);
   localparam int REC_CNT_W   = $clog2(MAX_REC + 1);
   localparam int Q_DEPTH     = 2;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

   localparam logic [1:0] KIND_SEG    = 2'd0;
   localparam logic [1:0] KIND_REL    = 2'd1;
   localparam logic [1:0] KIND_CMD    = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   localparam logic [CW_W-1:0] CW_START    = 16'h55d6;
   localparam logic [CW_W-1:0] CW_STOP     = 16'h55d7;
   localparam logic [CW_W-1:0] CW_STOP_ACK = 16'h55d8;

   localparam logic [CREDIT_W-1:0] CREDIT_MAX = '1;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_START  = 3'd1,
      OP_STOP   = 3'd2,
      OP_SUPPLY = 3'd3,
      OP_CHANGE = 3'd4,
      OP_CREDIT = 3'd5,
      OP_NONE   = 3'd6
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   addr_a;
      logic [SIZE_W-1:0]   size_a;
      logic [ADDR_W-1:0]   addr_b;
      logic [SIZE_W-1:0]   size_b;
      logic                accepted;
   } item_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [ADDR_W-1:0]   addr;
      logic [SIZE_W-1:0]   count;
      logic [CW_W-1:0]     cw;
   } rec_type;

   typedef struct packed {
      rec_type [MAX_REC-1:0]  rec;
      logic [REC_CNT_W-1:0]   n;
      logic [1:0]             state;
      logic                   ok;
   } bundle_type;

endpackage

@@ sv/ppasf_front.sv @@
// Input stage: takes request words and classifies the command code.
module ppasf_front import ppasf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic [ADDR_W-1:0]  req_addr_a,
   input  logic [SIZE_W-1:0]  req_size_a,
   input  logic [ADDR_W-1:0]  req_addr_b,
   input  logic [SIZE_W-1:0]  req_size_b,
   input  logic               req_queue_accepted,
   output logic               push,
   output item_type           push_item,
   input  logic               push_ready
);

   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_START  = 3'd1;
   localparam logic [2:0] CMD_STOP   = 3'd2;
   localparam logic [2:0] CMD_SUPPLY = 3'd3;
   localparam logic [2:0] CMD_CHANGE = 3'd4;
   localparam logic [2:0] CMD_CREDIT = 3'd5;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   op_type   op_dec;
   logic     take;

   always_comb begin
      unique case (req_cmd)
         CMD_TICK:   op_dec = OP_TICK;
         CMD_START:  op_dec = OP_START;
         CMD_STOP:   op_dec = OP_STOP;
         CMD_SUPPLY: op_dec = OP_SUPPLY;
         CMD_CHANGE: op_dec = OP_CHANGE;
         CMD_CREDIT: op_dec = OP_CREDIT;
         default:    op_dec = OP_NONE;
      endcase
   end

   assign push      = valid_ff && push_ready;
   assign push_item = item_ff;
   assign req_stall = valid_ff && !push_ready;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in         = 1'b1;
         item_in.op       = op_dec;
         item_in.addr_a   = req_addr_a;
         item_in.size_a   = req_size_a;
         item_in.addr_b   = req_addr_b;
         item_in.size_b   = req_size_b;
         item_in.accepted = req_queue_accepted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

@@ sv/ppasf_queue.sv @@
// Two-entry queue of classified words between the input stage and the engine.
module ppasf_queue import ppasf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   output logic      push_ready,
   input  logic      pop,
   output logic      head_valid,
   output item_type  head_item
);

   item_type             q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   assign push_ready = count_ff != Q_CNT_W'(Q_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + Q_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + Q_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != Q_CNT_W'(Q_DEPTH))
      else $error("word written into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("word taken from an empty queue");
`endif

endmodule

@@ sv/ppasf_engine.sv @@
// Stream engine: run state, buffer slots, credits and the block transfer sequencer.
module ppasf_engine import ppasf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  item_type    head_item,
   output logic        pop,
   input  logic        emit_ready,
   output logic        emit_load,
   output bundle_type  emit_bundle
);

   typedef enum logic [3:0] {
      RUN_OFF      = 4'b0001,
      RUN_STARTING = 4'b0010,
      RUN_ON       = 4'b0100,
      RUN_STOPPING = 4'b1000
   } run_type;

   typedef enum logic [7:0] {
      STEP_IDLE  = 8'b0000_0001,
      STEP_CALC  = 8'b0000_0010,
      STEP_SEG   = 8'b0000_0100,
      STEP_ADV2  = 8'b0000_1000,
      STEP_SEG2  = 8'b0001_0000,
      STEP_TAIL  = 8'b0010_0000,
      STEP_STOP2 = 8'b0100_0000,
      STEP_HAND  = 8'b1000_0000
   } step_type;

   localparam logic [1:0] STREAM_OFF      = 2'd0;
   localparam logic [1:0] STREAM_STARTING = 2'd1;
   localparam logic [1:0] STREAM_ON       = 2'd2;
   localparam logic [1:0] STREAM_STOPPING = 2'd3;

   localparam logic [SIZE_W-1:0] BLOCK_SIZE = SIZE_W'(BLOCK_WORDS);

   function automatic logic [1:0] run_code(run_type r);
      logic [1:0] code;
      unique case (r)
         RUN_OFF:      code = STREAM_OFF;
         RUN_STARTING: code = STREAM_STARTING;
         RUN_ON:       code = STREAM_ON;
         RUN_STOPPING: code = STREAM_STOPPING;
         default:      code = STREAM_OFF;
      endcase
      return code;
   endfunction

   run_type                 run_ff, run_in;
   step_type                step_ff, step_in;
   logic [ADDR_W-1:0]       slot_addr_ff [2];
   logic [ADDR_W-1:0]       slot_addr_in [2];
   logic [SIZE_W-1:0]       slot_size_ff [2];
   logic [SIZE_W-1:0]       slot_size_in [2];
   logic                    cur_slot_ff, cur_slot_in;
   logic [ADDR_W-1:0]       base_ff, base_in;
   logic [SIZE_W-1:0]       len_ff, len_in;
   logic [SIZE_W-1:0]       off_ff, off_in;
   logic [CREDIT_W-1:0]     credits_ff, credits_in;
   logic [SIZE_W-1:0]       y_ff, y_in;
   logic [ADDR_W-1:0]       sa_ff, sa_in;
   rec_type [MAX_REC-1:0]   rec_ff, rec_in;
   logic [REC_CNT_W-1:0]    n_ff, n_in;
   logic                    ok_ff, ok_in;

   logic                    finish;
   logic                    start_xfer;
   logic                    do_adv;
   logic                    use_credit;
   logic                    put;
   rec_type                 put_rec;
   logic [REC_IDX_W-1:0]    put_idx;
   logic                    adv_slot;
   logic                    adv_dead;
   logic                    off_ge_len;
   logic [SIZE_W-1:0]       moved;
   rec_type                 rel_rec;

   assign adv_slot   = ~cur_slot_ff;
   assign adv_dead   = slot_addr_ff[adv_slot] == '0;
   assign off_ge_len = off_ff >= len_ff;
   assign moved      = BLOCK_SIZE - y_ff;
   assign put_idx    = (step_ff == STEP_IDLE) ? '0 : n_ff[REC_IDX_W-1:0];

   always_comb begin
      rel_rec.kind  = KIND_REL;
      rel_rec.addr  = slot_addr_ff[cur_slot_ff];
      rel_rec.count = slot_size_ff[cur_slot_ff];
      rel_rec.cw    = '0;
   end

   always_comb begin
      run_in       = run_ff;
      step_in      = step_ff;
      slot_addr_in = slot_addr_ff;
      slot_size_in = slot_size_ff;
      cur_slot_in  = cur_slot_ff;
      base_in      = base_ff;
      len_in       = len_ff;
      off_in       = off_ff;
      credits_in   = credits_ff;
      y_in         = y_ff;
      sa_in        = sa_ff;
      rec_in       = rec_ff;
      n_in         = n_ff;
      ok_in        = ok_ff;
      finish       = 1'b0;
      start_xfer   = 1'b0;
      do_adv       = 1'b0;
      use_credit   = 1'b0;
      put          = 1'b0;
      put_rec      = '0;
      pop          = 1'b0;
      emit_load    = 1'b0;

      unique case (step_ff)
         STEP_IDLE: begin
            if (head_valid) begin
               pop   = 1'b1;
               ok_in = 1'b0;
               n_in  = '0;
               unique case (head_item.op)
                  OP_TICK: begin
                     unique case (run_ff)
                        RUN_OFF: begin
                           credits_in = '0;
                           finish     = 1'b1;
                        end
                        RUN_STARTING: begin
                           if (credits_ff > CREDIT_W'(1)) begin
                              start_xfer = 1'b1;
                           end else begin
                              if (head_item.accepted) begin
                                 put          = 1'b1;
                                 put_rec.kind = KIND_CMD;
                                 put_rec.cw   = CW_START;
                                 run_in       = RUN_ON;
                              end
                              finish = 1'b1;
                           end
                        end
                        RUN_ON: begin
                           if (credits_ff != '0) begin
                              start_xfer = 1'b1;
                           end else begin
                              finish = 1'b1;
                           end
                        end
                        RUN_STOPPING: begin
                           if (head_item.accepted) begin
                              put          = 1'b1;
                              put_rec.kind = KIND_CMD;
                              put_rec.cw   = CW_STOP;
                              step_in      = STEP_STOP2;
                           end else begin
                              finish = 1'b1;
                           end
                        end
                        default: begin
                           finish = 1'b1;
                        end
                     endcase
                  end
                  OP_START: begin
                     if (run_ff == RUN_OFF) begin
                        slot_addr_in[0] = head_item.addr_a;
                        slot_size_in[0] = head_item.size_a;
                        slot_addr_in[1] = head_item.addr_b;
                        slot_size_in[1] = head_item.size_b;
                        cur_slot_in     = 1'b0;
                        off_in          = '0;
                        base_in         = head_item.addr_a;
                        len_in          = head_item.size_a;
                        run_in          = RUN_STARTING;
                        credits_in      = '0;
                        ok_in           = 1'b1;
                     end
                     finish = 1'b1;
                  end
                  OP_STOP: begin
                     if (run_ff == RUN_ON) begin
                        run_in     = RUN_STOPPING;
                        credits_in = '0;
                        ok_in      = 1'b1;
                     end
                     finish = 1'b1;
                  end
                  OP_SUPPLY: begin
                     slot_addr_in[adv_slot] = head_item.addr_a;
                     slot_size_in[adv_slot] = head_item.size_a;
                     finish = 1'b1;
                  end
                  OP_CHANGE: begin
                     slot_addr_in[adv_slot]    = head_item.addr_a;
                     slot_size_in[adv_slot]    = head_item.size_a;
                     slot_addr_in[cur_slot_ff] = head_item.addr_b;
                     slot_size_in[cur_slot_ff] = head_item.size_b;
                     len_in = '0;
                     finish = 1'b1;
                  end
                  OP_CREDIT: begin
                     if (credits_ff != CREDIT_MAX) begin
                        credits_in = credits_ff + CREDIT_W'(1);
                     end
                     finish = 1'b1;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
               if (start_xfer) begin
                  if (off_ge_len) begin
                     do_adv = 1'b1;
                     if (adv_dead) begin
                        finish = 1'b1;
                     end else begin
                        step_in = STEP_CALC;
                     end
                  end else begin
                     step_in = STEP_CALC;
                  end
               end
            end
         end
         STEP_CALC: begin
            y_in    = len_ff - off_ff;
            sa_in   = base_ff + ADDR_W'(off_ff);
            step_in = STEP_SEG;
         end
         STEP_SEG: begin
            if (y_ff >= BLOCK_SIZE) begin
               put           = 1'b1;
               put_rec.kind  = KIND_SEG;
               put_rec.addr  = sa_ff;
               put_rec.count = BLOCK_SIZE;
               use_credit    = 1'b1;
               off_in        = off_ff + BLOCK_SIZE;
               step_in       = STEP_TAIL;
            end else if (y_ff == '0) begin
               finish = 1'b1;
            end else begin
               put           = 1'b1;
               put_rec.kind  = KIND_SEG;
               put_rec.addr  = sa_ff;
               put_rec.count = y_ff;
               step_in       = STEP_ADV2;
            end
         end
         STEP_ADV2: begin
            do_adv = 1'b1;
            if (adv_dead) begin
               use_credit = 1'b1;
               finish     = 1'b1;
            end else begin
               step_in = STEP_SEG2;
            end
         end
         STEP_SEG2: begin
            put           = 1'b1;
            put_rec.kind  = KIND_SEG;
            put_rec.addr  = base_ff;
            put_rec.count = moved;
            use_credit    = 1'b1;
            off_in        = moved;
            step_in       = STEP_TAIL;
         end
         STEP_TAIL: begin
            if (off_ge_len) begin
               do_adv = 1'b1;
            end
            finish = 1'b1;
         end
         STEP_STOP2: begin
            put          = 1'b1;
            put_rec.kind = KIND_CMD;
            put_rec.cw   = CW_STOP_ACK;
            credits_in   = '0;
            run_in       = RUN_OFF;
            finish       = 1'b1;
         end
         STEP_HAND: begin
            finish = 1'b0;
         end
         default: begin
            step_in = STEP_IDLE;
         end
      endcase

      if (do_adv) begin
         put                        = 1'b1;
         put_rec                    = rel_rec;
         slot_addr_in[cur_slot_ff]  = '0;
         slot_size_in[cur_slot_ff]  = '0;
         cur_slot_in                = adv_slot;
         base_in                    = slot_addr_ff[adv_slot];
         len_in                     = slot_size_ff[adv_slot];
         off_in                     = '0;
         if (adv_dead) begin
            run_in = RUN_STOPPING;
         end
      end

      if (use_credit && credits_ff != '0) begin
         credits_in = credits_ff - CREDIT_W'(1);
      end

      if (put) begin
         rec_in[put_idx] = put_rec;
         n_in            = REC_CNT_W'(put_idx) + REC_CNT_W'(1);
      end

      if (finish || step_ff == STEP_HAND) begin
         if (emit_ready) begin
            emit_load = 1'b1;
            step_in   = STEP_IDLE;
         end else begin
            step_in = STEP_HAND;
         end
      end
   end

   always_comb begin
      emit_bundle.rec   = rec_in;
      emit_bundle.n     = n_in;
      emit_bundle.state = run_code(run_in);
      emit_bundle.ok    = ok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff          <= RUN_OFF;
         step_ff         <= STEP_IDLE;
         slot_addr_ff[0] <= '0;
         slot_addr_ff[1] <= '0;
         slot_size_ff[0] <= '0;
         slot_size_ff[1] <= '0;
         cur_slot_ff     <= 1'b0;
         base_ff         <= '0;
         len_ff          <= '0;
         off_ff          <= '0;
         credits_ff      <= '0;
         n_ff            <= '0;
      end else begin
         run_ff       <= run_in;
         step_ff      <= step_in;
         slot_addr_ff <= slot_addr_in;
         slot_size_ff <= slot_size_in;
         cur_slot_ff  <= cur_slot_in;
         base_ff      <= base_in;
         len_ff       <= len_in;
         off_ff       <= off_in;
         credits_ff   <= credits_in;
         n_ff         <= n_in;
      end
      y_ff   <= y_in;
      sa_ff  <= sa_in;
      rec_ff <= rec_in;
      ok_ff  <= ok_in;
   end

`ifndef SYNTHESIS
   a_xfer_only_streaming: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_CALC || step_ff == STEP_SEG || step_ff == STEP_ADV2 ||
       step_ff == STEP_SEG2 || step_ff == STEP_TAIL)
      |-> (run_ff == RUN_STARTING || run_ff == RUN_ON))
      else $error("block transfer running while the stream is not active");

   a_record_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= REC_CNT_W'(MAX_REC))
      else $error("more result words built than the buffer holds");
`endif

endmodule

@@ sv/ppasf_emit.sv @@
// Output stage: holds one finished item and sends its words one per cycle while rsp_stall is low.
module ppasf_emit import ppasf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               emit_load,
   input  bundle_type         emit_bundle,
   output logic               emit_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [ADDR_W-1:0]  rsp_seg_addr,
   output logic [SIZE_W-1:0]  rsp_seg_count,
   output logic [CW_W-1:0]    rsp_command_word,
   output logic [1:0]         rsp_stream_state,
   output logic               rsp_op_ok,
   output logic               rsp_last
);

   bundle_type             bundle_ff;
   logic                   full_ff, full_in;
   logic [REC_CNT_W-1:0]   idx_ff, idx_in;
   logic                   take;
   logic                   at_status;
   rec_type                cur_rec;

   assign take       = full_ff && !rsp_stall;
   assign at_status  = idx_ff == bundle_ff.n;
   assign emit_ready = !full_ff || (take && at_status);
   assign cur_rec    = bundle_ff.rec[idx_ff[REC_IDX_W-1:0]];

   always_comb begin
      full_in = full_ff;
      idx_in  = idx_ff;
      if (take) begin
         if (at_status) begin
            full_in = 1'b0;
         end else begin
            idx_in = idx_ff + REC_CNT_W'(1);
         end
      end
      if (emit_load) begin
         full_in = 1'b1;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         full_ff <= full_in;
         idx_ff  <= idx_in;
      end
      if (emit_load) begin
         bundle_ff <= emit_bundle;
      end
   end

   assign rsp_valid        = full_ff;
   assign rsp_kind         = at_status ? KIND_STATUS : cur_rec.kind;
   assign rsp_seg_addr     = at_status ? '0 : cur_rec.addr;
   assign rsp_seg_count    = at_status ? '0 : cur_rec.count;
   assign rsp_command_word = at_status ? '0 : cur_rec.cw;
   assign rsp_stream_state = bundle_ff.state;
   assign rsp_op_ok        = at_status && bundle_ff.ok;
   assign rsp_last         = at_status;

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      emit_load |-> (!full_ff || (take && at_status)))
      else $error("new item loaded over one still being sent");
`endif

endmodule

@@ sv/ping_pong_audio_stream_feeder.sv @@
// Top level of the ping-pong audio stream feeder.
// Each request word is one command: a service tick, start, stop, supply of the next
// buffer, change of both buffers, or one returned block credit. Every request yields
// one to six response words, sent one per cycle while rsp_stall is low, ending with a
// status word that has last set; all words of a request carry the stream state after
// that request. Start, stop, buffer and credit commands are finished in the engine's
// idle step, so such requests flow at one per cycle while the response side keeps up.
// A service tick that moves a block runs through the transfer sequencer, which
// computes the remaining length and the segment address, emits at most one segment or
// buffer release per cycle, and releases used-up buffers. A two-word queue between the
// input stage and the engine, and a finished-item register on the output, let each
// side stall on its own. No clearing pass is needed after reset.
module ping_pong_audio_stream_feeder import ppasf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic [ADDR_W-1:0]  req_addr_a,
   input  logic [SIZE_W-1:0]  req_size_a,
   input  logic [ADDR_W-1:0]  req_addr_b,
   input  logic [SIZE_W-1:0]  req_size_b,
   input  logic               req_queue_accepted,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [ADDR_W-1:0]  rsp_seg_addr,
   output logic [SIZE_W-1:0]  rsp_seg_count,
   output logic [CW_W-1:0]    rsp_command_word,
   output logic [1:0]         rsp_stream_state,
   output logic               rsp_op_ok,
   output logic               rsp_last
);

   logic        push;
   item_type    push_item;
   logic        push_ready;
   logic        pop;
   logic        head_valid;
   item_type    head_item;
   logic        emit_ready;
   logic        emit_load;
   bundle_type  emit_bundle;

   ppasf_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_addr_a         (req_addr_a),
      .req_size_a         (req_size_a),
      .req_addr_b         (req_addr_b),
      .req_size_b         (req_size_b),
      .req_queue_accepted (req_queue_accepted),
      .push               (push),
      .push_item          (push_item),
      .push_ready         (push_ready)
   );

   ppasf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   ppasf_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_item   (head_item),
      .pop         (pop),
      .emit_ready  (emit_ready),
      .emit_load   (emit_load),
      .emit_bundle (emit_bundle)
   );

   ppasf_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .emit_load        (emit_load),
      .emit_bundle      (emit_bundle),
      .emit_ready       (emit_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_seg_addr     (rsp_seg_addr),
      .rsp_seg_count    (rsp_seg_count),
      .rsp_command_word (rsp_command_word),
      .rsp_stream_state (rsp_stream_state),
      .rsp_op_ok        (rsp_op_ok),
      .rsp_last         (rsp_last)
   );

endmodule

@@ dv/ping_pong_audio_stream_feeder_tb.sv @@
// Self-checking testbench for the ping-pong audio stream feeder, with its own stream predictor.
`timescale 1ns / 1ps

module ping_pong_audio_stream_feeder_tb;
   import ppasf_pkg::*;

   localparam logic [1:0] ST_OFF      = 2'd0;
   localparam logic [1:0] ST_STARTING = 2'd1;
   localparam logic [1:0] ST_ON       = 2'd2;
   localparam logic [1:0] ST_STOPPING = 2'd3;

   localparam int DIRECTED_ROWS = 26;
   localparam int RANDOM_ITEMS  = 134;
   localparam int HOLD_CYCLES   = 150;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] count;
      logic [CW_W-1:0]   cw;
      logic [1:0]        state;
      logic              ok;
      logic              last;
   } feeder_word_type;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [ADDR_W-1:0] addr_a;
      logic [SIZE_W-1:0] size_a;
      logic [ADDR_W-1:0] addr_b;
      logic [SIZE_W-1:0] size_b;
      logic              acc;
      logic              typed;
      logic [1:0]        t_state;
      logic              t_ok;
   } cmd_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [2:0]        req_cmd;
   logic [ADDR_W-1:0] req_addr_a;
   logic [SIZE_W-1:0] req_size_a;
   logic [ADDR_W-1:0] req_addr_b;
   logic [SIZE_W-1:0] req_size_b;
   logic              req_queue_accepted;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_kind;
   logic [ADDR_W-1:0] rsp_seg_addr;
   logic [SIZE_W-1:0] rsp_seg_count;
   logic [CW_W-1:0]   rsp_command_word;
   logic [1:0]        rsp_stream_state;
   logic              rsp_op_ok;
   logic              rsp_last;

   ping_pong_audio_stream_feeder uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_addr_a         (req_addr_a),
      .req_size_a         (req_size_a),
      .req_addr_b         (req_addr_b),
      .req_size_b         (req_size_b),
      .req_queue_accepted (req_queue_accepted),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_seg_addr       (rsp_seg_addr),
      .rsp_seg_count      (rsp_seg_count),
      .rsp_command_word   (rsp_command_word),
      .rsp_stream_state   (rsp_stream_state),
      .rsp_op_ok          (rsp_op_ok),
      .rsp_last           (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predicted stream state.
   logic [1:0]          run_state    = ST_OFF;
   logic [ADDR_W-1:0]   slot_addr [2] = '{'0, '0};
   logic [SIZE_W-1:0]   slot_size [2] = '{'0, '0};
   bit                  cur_slot     = 1'b0;
   logic [ADDR_W-1:0]   cur_base     = '0;
   logic [SIZE_W-1:0]   cur_length   = '0;
   logic [SIZE_W-1:0]   cur_offset   = '0;
   logic [CREDIT_W-1:0] free_credits = '0;
   logic [CREDIT_W-1:0] filled_count = '0;
   bit                  streaming    = 1'b0;

   feeder_word_type item_words [$];
   feeder_word_type words_due [$];
   cmd_row_type     directed_rows [DIRECTED_ROWS];

   int  mismatches  = 0;
   int  cycle_count = 0;
   bit  long_hold   = 1'b0;
   bit  req_burst   = 1'b0;
   bit  rsp_burst   = 1'b0;

   function automatic void emit_word(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                                     input logic [SIZE_W-1:0] count, input logic [CW_W-1:0] cw);
      feeder_word_type w;
      w.kind  = kind;
      w.addr  = addr;
      w.count = count;
      w.cw    = cw;
      w.state = ST_OFF;
      w.ok    = 1'b0;
      w.last  = 1'b0;
      if (item_words.size() < MAX_REC) item_words.push_back(w);
   endfunction

   function automatic void take_credit();
      if (free_credits != '0) free_credits = free_credits - 1'b1;
      if (filled_count != CREDIT_MAX) filled_count = filled_count + 1'b1;
   endfunction

   function automatic bit release_slot();
      emit_word(KIND_REL, slot_addr[cur_slot], slot_size[cur_slot], '0);
      slot_addr[cur_slot] = '0;
      slot_size[cur_slot] = '0;
      cur_slot   = ~cur_slot;
      cur_base   = slot_addr[cur_slot];
      cur_length = slot_size[cur_slot];
      cur_offset = '0;
      if (cur_base == '0) begin
         run_state = ST_STOPPING;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void move_block();
      logic [SIZE_W-1:0] remain;
      logic [SIZE_W-1:0] moved;
      if (cur_offset >= cur_length) begin
         if (!release_slot()) return;
      end
      remain = cur_length - cur_offset;
      if (remain >= BLOCK_WORDS) begin
         emit_word(KIND_SEG, cur_base + ADDR_W'(cur_offset), SIZE_W'(BLOCK_WORDS), '0);
         take_credit();
         moved = SIZE_W'(BLOCK_WORDS);
      end else begin
         if (remain == '0) return;
         emit_word(KIND_SEG, cur_base + ADDR_W'(cur_offset), remain, '0);
         if (!release_slot()) begin
            take_credit();
            return;
         end
         // The second part of a split block always runs to a full block.
         moved = SIZE_W'(BLOCK_WORDS) - remain;
         emit_word(KIND_SEG, cur_base, moved, '0);
         take_credit();
      end
      cur_offset = cur_offset + moved;
      if (cur_offset >= cur_length) void'(release_slot());
   endfunction

   function automatic void service_tick(input logic acc);
      case (run_state)
         ST_OFF: begin
            free_credits = '0;
            streaming    = 1'b0;
         end
         ST_STARTING: begin
            if (free_credits > 1) begin
               move_block();
            end else if (acc) begin
               emit_word(KIND_CMD, '0, '0, CW_START);
               run_state = ST_ON;
            end
         end
         ST_ON: begin
            if (free_credits != '0) move_block();
         end
         default: begin
            if (acc) begin
               emit_word(KIND_CMD, '0, '0, CW_STOP);
               emit_word(KIND_CMD, '0, '0, CW_STOP_ACK);
               streaming    = 1'b0;
               free_credits = '0;
               run_state    = ST_OFF;
            end
         end
      endcase
   endfunction

   function automatic void feed_step(input cmd_row_type r);
      feeder_word_type w;
      logic            ok;
      bit              other;
      ok    = 1'b0;
      other = ~cur_slot;
      item_words.delete();
      case (r.cmd)
         OP_TICK: service_tick(r.acc);
         OP_START: begin
            if (run_state == ST_OFF) begin
               slot_addr[0] = r.addr_a;
               slot_size[0] = r.size_a;
               slot_addr[1] = r.addr_b;
               slot_size[1] = r.size_b;
               cur_slot     = 1'b0;
               cur_offset   = '0;
               cur_base     = r.addr_a;
               cur_length   = r.size_a;
               run_state    = ST_STARTING;
               free_credits = '0;
               streaming    = 1'b1;
               ok           = 1'b1;
            end
         end
         OP_STOP: begin
            if (run_state == ST_ON) begin
               run_state    = ST_STOPPING;
               free_credits = '0;
               ok           = 1'b1;
            end
         end
         OP_SUPPLY: begin
            slot_addr[other] = r.addr_a;
            slot_size[other] = r.size_a;
         end
         OP_CHANGE: begin
            slot_addr[other]    = r.addr_a;
            slot_size[other]    = r.size_a;
            cur_length          = '0;
            slot_addr[cur_slot] = r.addr_b;
            slot_size[cur_slot] = r.size_b;
         end
         OP_CREDIT: begin
            if (free_credits != CREDIT_MAX) free_credits = free_credits + 1'b1;
         end
         default: ;
      endcase
      w.kind  = KIND_STATUS;
      w.addr  = '0;
      w.count = '0;
      w.cw    = '0;
      w.state = ST_OFF;
      w.ok    = ok;
      w.last  = 1'b1;
      item_words.push_back(w);
      foreach (item_words[i]) item_words[i].state = run_state;
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      return ($urandom_range(0, 7) == 0) ? '0 : ADDR_W'($urandom);
   endfunction

   function automatic logic [SIZE_W-1:0] rand_size();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return SIZE_W'($urandom);
      if (pick < 3) return SIZE_W'($urandom_range(0, 3));
      return SIZE_W'($urandom_range(1, 720));
   endfunction

   function automatic cmd_row_type random_item();
      cmd_row_type r;
      int          pick;
      r        = '0;
      r.addr_a = rand_addr();
      r.size_a = rand_size();
      r.addr_b = rand_addr();
      r.size_b = rand_size();
      r.acc    = ($urandom_range(0, 3) != 0);
      pick     = $urandom_range(0, 99);
      if (run_state == ST_OFF) begin
         if (pick < 70) r.cmd = OP_START;
         else if (pick < 80) r.cmd = OP_TICK;
         else if (pick < 90) r.cmd = OP_CREDIT;
         else r.cmd = 3'($urandom_range(2, 7));
      end else if (run_state == ST_STOPPING) begin
         if (pick < 75) r.cmd = OP_TICK;
         else r.cmd = 3'($urandom_range(0, 7));
      end else begin
         if (pick < 38) r.cmd = OP_CREDIT;
         else if (pick < 76) r.cmd = OP_TICK;
         else if (pick < 86) r.cmd = OP_SUPPLY;
         else if (pick < 90) r.cmd = OP_CHANGE;
         else if (pick < 94) r.cmd = OP_STOP;
         else if (pick < 97) r.cmd = OP_START;
         else r.cmd = 3'($urandom_range(6, 7));
      end
      return r;
   endfunction

   task automatic send_cmd(input cmd_row_type r, input bit pause);
      int gap;
      if ($urandom_range(0, 15) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 11);
      if (pause && gap == 0) gap = 1;
      if (gap > 0) begin
         req_valid <= 1'b0;
         if (pause) begin
            while (words_due.size() != 0) @(negedge clock);
         end
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_cmd            <= r.cmd;
      req_addr_a         <= r.addr_a;
      req_size_a         <= r.size_a;
      req_addr_b         <= r.addr_b;
      req_size_b         <= r.size_b;
      req_queue_accepted <= r.acc;
      do @(posedge clock); while (req_stall);
      feed_step(r);
      if (r.typed) begin
         words_due.push_back('{kind: KIND_STATUS, addr: '0, count: '0, cw: '0,
                               state: r.t_state, ok: r.t_ok, last: 1'b1});
      end else begin
         foreach (item_words[i]) words_due.push_back(item_words[i]);
      end
      @(negedge clock);
   endtask

   initial begin
      int n;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_cmd            = '0;
      req_addr_a         = '0;
      req_size_a         = '0;
      req_addr_b         = '0;
      req_size_b         = '0;
      req_queue_accepted = 1'b0;
      directed_rows = '{
         '{OP_TICK,    32'h0,         24'd0,       32'h0,         24'd0,       1'b1, 1'b1,
           ST_OFF, 1'b0},
         '{OP_STOP,    32'h0,         24'd0,       32'h0,         24'd0,       1'b1, 1'b1,
           ST_OFF, 1'b0},
         '{OP_CREDIT,  32'h0,         24'd0,       32'h0,         24'd0,       1'b0, 1'b1,
           ST_OFF, 1'b0},
         '{OP_START,   32'hFFFF_FFA0, 24'd500,     32'h0000_8000, 24'd100,     1'b0, 1'b1,
           ST_STARTING, 1'b1},
         '{OP_START,   32'h0000_1234, 24'd5,       32'h0000_5678, 24'd6,       1'b1, 1'b1,
           ST_STARTING, 1'b0},
         '{OP_TICK,    32'h0,         24'd0,       32'h0,         24'd0,       1'b0, 1'b1,
           ST_STARTING, 1'b0},
         '{OP_CREDIT,  32'h0,         24'd0,       32'h0,         24'd0,       1'b0, 1'b1,
           ST_STARTING, 1'b0},
         '{OP_CREDIT,  32'h0,         24'd0,       32'h0,         24'd0,       1'b0, 1'b1,
           ST_STARTING, 1'b0},
         '{OP_CREDIT,  32'h0,         24'd0,       32'h0,         24'd0,       1'b0, 1'b1,
           ST_STARTING, 1'b0},
         '{OP_TICK,    32'h0,         24'd0,       32'h0,         24'd0,       1'b0, 1'b0,
           ST_OFF, 1'b0},
         '{OP_TICK,    32'h0,         24'd0,       32'h0,         24'd0,       1'b0, 1'b0,
           ST_OFF, 1'b0},
         '{OP_TICK,    32'h0,         24'd0,       32'h0,         24'd0,       1'b1, 1'b0,
           ST_OFF, 1'b0},
         '{OP_TICK,    32'h0,         24'd0,       32'h0,         24'd0,       1'b0, 1'b0,
           ST_OFF, 1'b0},
         '{OP_STOP,    32'h0,         24'd0,       32'h0,         24'd0,       1'b1, 1'b1,
           ST_STOPPING, 1'b0},
         '{OP_TICK,    32'h0,         24'd0,       32'h0,         24'd0,       1'b0, 1'b1,
           ST_STOPPING, 1'b0},
         '{OP_TICK,    32'h0,         24'd0,       32'h0,         24'd0,       1'b1, 1'b0,
           ST_OFF, 1'b0},
         '{OP_START,   32'h0000_1000, 24'hFF_FFFF, 32'h0,         24'd0,       1'b0, 1'b1,
           ST_STARTING, 1'b1},
         '{OP_CREDIT,  32'h0,         24'd0,       32'h0,         24'd0,       1'b0, 1'b1,
           ST_STARTING, 1'b0},
         '{OP_TICK,    32'h0,         24'd0,       32'h0,         24'd0,       1'b1, 1'b0,
           ST_OFF, 1'b0},
         '{OP_CHANGE,  32'h0000_3000, 24'd0,       32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b1,
           ST_ON, 1'b0},
         '{OP_TICK,    32'h0,         24'd0,       32'h0,         24'd0,       1'b1, 1'b0,
           ST_OFF, 1'b0},
         '{OP_SUPPLY,  32'h0000_4000, 24'd300,     32'h0,         24'd0,       1'b0, 1'b1,
           ST_ON, 1'b0},
         '{OP_TICK,    32'h0,         24'd0,       32'h0,         24'd0,       1'b0, 1'b0,
           ST_OFF, 1'b0},
         '{OP_STOP,    32'h0,         24'd0,       32'h0,         24'd0,       1'b0, 1'b1,
           ST_STOPPING, 1'b1},
         '{OP_TICK,    32'h0,         24'd0,       32'h0,         24'd0,       1'b1, 1'b0,
           ST_OFF, 1'b0},
         '{3'd7,       32'h0,         24'd0,       32'h0,         24'd0,       1'b1, 1'b1,
           ST_OFF, 1'b0}
      };
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) send_cmd(directed_rows[i], 1'b0);
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 40) long_hold = 1'b1;
         send_cmd(random_item(), n == 100);
      end
      req_valid <= 1'b0;
      while (words_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Response side: a random stall before each word, and one long hold-off on request.
   initial begin
      int gap;
      rsp_stall = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if ($urandom_range(0, 15) == 0) rsp_burst = !rsp_burst;
         gap = rsp_burst ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      feeder_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (words_due.size() == 0) begin
            $error("unexpected word: kind %0d, state %0d", rsp_kind, rsp_stream_state);
            mismatches++;
         end else begin
            w = words_due.pop_front();
            if (rsp_kind !== w.kind) begin
               $error("kind: expected %0d, actual %0d", w.kind, rsp_kind);
               mismatches++;
            end
            if (rsp_seg_addr !== w.addr) begin
               $error("seg_addr: expected %h, actual %h", w.addr, rsp_seg_addr);
               mismatches++;
            end
            if (rsp_seg_count !== w.count) begin
               $error("seg_count: expected %0d, actual %0d", w.count, rsp_seg_count);
               mismatches++;
            end
            if (rsp_command_word !== w.cw) begin
               $error("command_word: expected %h, actual %h", w.cw, rsp_command_word);
               mismatches++;
            end
            if (rsp_stream_state !== w.state) begin
               $error("stream_state: expected %0d, actual %0d", w.state, rsp_stream_state);
               mismatches++;
            end
            if (rsp_op_ok !== w.ok) begin
               $error("op_ok: expected %0d, actual %0d", w.ok, rsp_op_ok);
               mismatches++;
            end
            if (rsp_last !== w.last) begin
               $error("last: expected %0d, actual %0d", w.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
